>>> sv/sbsd_pkg.sv
// Shared types, constants and the opcode table of the bytecode stream decoder.
// No dependencies; every other file refers to it by scoped names.
package sbsd_pkg;

   localparam int OFFSET_BITS_DEF   = 32;
   localparam int OPERAND_BYTES_DEF = 4;

   localparam int WORD_W = 32;

   // result kinds
   typedef enum logic [1:0] {
      KIND_INSTR   = 2'd0,
      KIND_CAPTURE = 2'd1,
      KIND_END     = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_OPCODE  = 2'd0,
      PH_OPERAND = 2'd1,
      PH_AREA    = 2'd2,
      PH_INDEX   = 2'd3
   } phase_type;

   localparam logic [3:0] MAJOR_END       = 4'hF;
   localparam logic [3:0] MAJOR_CTRL      = 4'h5;
   localparam logic [3:0] MINOR_CLOSURE   = 4'h4;
   localparam logic [7:0] AREA_MAX        = 8'd3;
   localparam logic [7:0] MAJOR_MASK      = 8'hF0;
   localparam logic [7:0] MINOR_MASK      = 8'h0F;

   typedef struct packed {
      logic       valid;
      logic [1:0] count;
   } op_info_type;

   typedef struct packed {
      kind_type           kind;
      logic [31:0]        start_offset;
      logic [3:0]         major_code;
      logic [3:0]         minor_code;
      logic signed [31:0] first_operand;
      logic signed [31:0] second_operand;
      logic [1:0]         operand_count;
      logic [1:0]         capture_area;
      logic               last_of_instruction;
   } rsp_payload_type;

   // operand count of an opcode; valid is low for an undefined opcode
   function automatic op_info_type op_info(input logic [3:0] major, input logic [3:0] minor);
      op_info_type r;
      r = '{valid: 1'b0, count: 2'd0};
      unique case (major)
         4'h0: begin
            r.valid = (minor >= 4'd1) && (minor <= 4'd13);
         end
         4'h1: begin
            unique case (minor)
               4'h0, 4'h1, 4'h5: r = '{valid: 1'b1, count: 2'd1};
               4'h2:             r = '{valid: 1'b1, count: 2'd2};
               4'h3, 4'h4, 4'h6, 4'h7, 4'h8, 4'h9, 4'hA, 4'hB:
                                 r = '{valid: 1'b1, count: 2'd0};
               default:          r = '{valid: 1'b0, count: 2'd0};
            endcase
         end
         4'h2, 4'h3, 4'h4: begin
            r = '{valid: (minor <= 4'd3), count: 2'd1};
         end
         4'h5: begin
            unique case (minor)
               4'h0, 4'h1, 4'h5, 4'h8, 4'hA: r = '{valid: 1'b1, count: 2'd1};
               4'h2, 4'h3, 4'h4, 4'h6, 4'h7, 4'h9, 4'hB:
                                             r = '{valid: 1'b1, count: 2'd2};
               default:                      r = '{valid: 1'b0, count: 2'd0};
            endcase
         end
         4'h6: begin
            r.valid = (minor <= 4'd6);
         end
         4'h7: begin
            if (minor <= 4'd3) begin
               r = '{valid: 1'b1, count: 2'd0};
            end else if (minor == 4'd4) begin
               r = '{valid: 1'b1, count: 2'd1};
            end
         end
         default: begin
            r = '{valid: 1'b0, count: 2'd0};
         end
      endcase
      return r;
   endfunction

endpackage

>>> sv/sbsd_if.sv
// Valid/ready channel interfaces for the bytecode stream decoder.
// Depends on sbsd_pkg for the result kind type.
interface sbsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;

   modport source (output valid, output code_byte, input ready);
   modport sink   (input valid, input code_byte, output ready);
endinterface

interface sbsd_rsp_if;
   logic               valid;
   logic               ready;
   sbsd_pkg::kind_type kind;
   logic [31:0]        start_offset;
   logic [3:0]         major_code;
   logic [3:0]         minor_code;
   logic signed [31:0] first_operand;
   logic signed [31:0] second_operand;
   logic [1:0]         operand_count;
   logic [1:0]         capture_area;
   logic               last_of_instruction;

   modport source (output valid, output kind, output start_offset, output major_code,
                   output minor_code, output first_operand, output second_operand,
                   output operand_count, output capture_area,
                   output last_of_instruction, input ready);
   modport sink   (input valid, input kind, input start_offset, input major_code,
                   input minor_code, input first_operand, input second_operand,
                   input operand_count, input capture_area,
                   input last_of_instruction, output ready);
endinterface

>>> sv/sbsd_operand_gather.sv
// Little-endian operand word assembly, one byte per enabled cycle.
// Depends on sbsd_pkg for the word width.
module sbsd_operand_gather #(
   parameter int OPERAND_BYTES = sbsd_pkg::OPERAND_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic [7:0]                code_byte,
   output logic                      word_done,
   output logic signed [31:0]        word_value
);
   localparam int BITS  = 8 * OPERAND_BYTES;
   localparam int IDX_W = $clog2(OPERAND_BYTES);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [BITS-1:0]  word_ff, word_in;

   always_comb begin
      word_in = word_ff;
      word_in[idx_ff*8 +: 8] = code_byte;
   end

   assign word_done = enable && (idx_ff == IDX_W'(OPERAND_BYTES - 1));
   assign idx_in    = !enable ? idx_ff : (word_done ? '0 : idx_ff + 1'b1);

   // sign-extend from the operand width, or keep the low 32 bits
   generate
      if (BITS < sbsd_pkg::WORD_W) begin : g_ext
         assign word_value = {{(sbsd_pkg::WORD_W - BITS){word_in[BITS-1]}}, word_in};
      end else begin : g_cut
         assign word_value = word_in[sbsd_pkg::WORD_W-1:0];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= word_in;
      end
   end
endmodule

>>> sv/sbsd_decoder.sv
// Per-byte decode state machine: opcode check, operand sequencing, capture list.
// Depends on sbsd_pkg and sbsd_operand_gather.
module sbsd_decoder #(
   parameter int OFFSET_BITS   = sbsd_pkg::OFFSET_BITS_DEF,
   parameter int OPERAND_BYTES = sbsd_pkg::OPERAND_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                code_byte,
   output logic                      emit,
   output sbsd_pkg::rsp_payload_type payload
);
   sbsd_pkg::phase_type       phase_ff, phase_in;
   logic                      halted_ff, halted_in;
   logic [3:0]                held_major_ff, held_minor_ff;
   logic                      more_words_ff;
   logic signed [31:0]        saved_first_ff;
   logic [31:0]               captures_left_ff;
   logic [1:0]                held_area_ff;
   logic [OFFSET_BITS-1:0]    byte_position_ff, instr_offset_ff;

   logic                      live;
   logic                      gather_en;
   logic                      word_done;
   logic signed [31:0]        word_value;
   logic [3:0]                byte_major, byte_minor;
   sbsd_pkg::op_info_type     byte_info, held_info;
   logic                      capt_start;
   logic                      area_bad;
   logic                      last_capture;

   assign live       = step && !halted_ff;
   assign gather_en  = live && (phase_ff == sbsd_pkg::PH_OPERAND ||
                                phase_ff == sbsd_pkg::PH_INDEX);
   assign byte_major = 4'((code_byte & sbsd_pkg::MAJOR_MASK) >> 4);
   assign byte_minor = 4'(code_byte & sbsd_pkg::MINOR_MASK);
   assign byte_info  = sbsd_pkg::op_info(byte_major, byte_minor);
   assign held_info  = sbsd_pkg::op_info(held_major_ff, held_minor_ff);
   assign area_bad   = code_byte > sbsd_pkg::AREA_MAX;
   assign last_capture = captures_left_ff == 32'd1;
   // closure with a positive capture count
   assign capt_start = held_major_ff == sbsd_pkg::MAJOR_CTRL &&
                       held_minor_ff == sbsd_pkg::MINOR_CLOSURE &&
                       word_value != 32'sd0 && !word_value[31];

   sbsd_operand_gather #(.OPERAND_BYTES(OPERAND_BYTES)) u_gather (
      .clock      (clock),
      .reset      (reset),
      .enable     (gather_en),
      .code_byte  (code_byte),
      .word_done  (word_done),
      .word_value (word_value)
   );

   // next state
   always_comb begin
      phase_in  = phase_ff;
      halted_in = halted_ff;
      if (live) begin
         unique case (phase_ff)
            sbsd_pkg::PH_OPCODE: begin
               if (byte_major == sbsd_pkg::MAJOR_END || !byte_info.valid) begin
                  halted_in = 1'b1;
               end else if (byte_info.count != 2'd0) begin
                  phase_in = sbsd_pkg::PH_OPERAND;
               end
            end
            sbsd_pkg::PH_OPERAND: begin
               if (word_done && !more_words_ff) begin
                  phase_in = (held_info.count == 2'd2 && capt_start) ?
                             sbsd_pkg::PH_AREA : sbsd_pkg::PH_OPCODE;
               end
            end
            sbsd_pkg::PH_AREA: begin
               if (area_bad) begin
                  halted_in = 1'b1;
               end else begin
                  phase_in = sbsd_pkg::PH_INDEX;
               end
            end
            sbsd_pkg::PH_INDEX: begin
               if (word_done) begin
                  phase_in = last_capture ? sbsd_pkg::PH_OPCODE : sbsd_pkg::PH_AREA;
               end
            end
            default: phase_in = sbsd_pkg::PH_OPCODE;
         endcase
      end
   end

   // result
   always_comb begin
      emit    = 1'b0;
      payload = '0;
      payload.kind                = sbsd_pkg::KIND_INSTR;
      payload.start_offset        = 32'(instr_offset_ff);
      payload.major_code          = held_major_ff;
      payload.minor_code          = held_minor_ff;
      payload.last_of_instruction = 1'b1;
      unique case (phase_ff)
         sbsd_pkg::PH_OPCODE: begin
            payload.start_offset = 32'(byte_position_ff);
            payload.major_code   = byte_major;
            payload.minor_code   = byte_minor;
            if (byte_major == sbsd_pkg::MAJOR_END) begin
               emit         = 1'b1;
               payload.kind = sbsd_pkg::KIND_END;
            end else if (!byte_info.valid) begin
               emit         = 1'b1;
               payload.kind = sbsd_pkg::KIND_ERROR;
            end else if (byte_info.count == 2'd0) begin
               emit         = 1'b1;
            end
         end
         sbsd_pkg::PH_OPERAND: begin
            if (word_done && !more_words_ff) begin
               emit = 1'b1;
               if (held_info.count == 2'd2) begin
                  payload.first_operand       = saved_first_ff;
                  payload.second_operand      = word_value;
                  payload.operand_count       = 2'd2;
                  payload.last_of_instruction = !capt_start;
               end else begin
                  payload.first_operand = word_value;
                  payload.operand_count = 2'd1;
               end
            end
         end
         sbsd_pkg::PH_AREA: begin
            if (area_bad) begin
               emit                  = 1'b1;
               payload.kind          = sbsd_pkg::KIND_ERROR;
               payload.first_operand = 32'(code_byte);
            end
         end
         sbsd_pkg::PH_INDEX: begin
            if (word_done) begin
               emit                        = 1'b1;
               payload.kind                = sbsd_pkg::KIND_CAPTURE;
               payload.first_operand       = word_value;
               payload.operand_count       = 2'd1;
               payload.capture_area        = held_area_ff;
               payload.last_of_instruction = last_capture;
            end
         end
         default: emit = 1'b0;
      endcase
      emit = emit && live;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= sbsd_pkg::PH_OPCODE;
         halted_ff        <= 1'b0;
         held_major_ff    <= '0;
         held_minor_ff    <= '0;
         more_words_ff    <= 1'b0;
         saved_first_ff   <= '0;
         captures_left_ff <= '0;
         held_area_ff     <= '0;
         byte_position_ff <= '0;
         instr_offset_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         halted_ff <= halted_in;
         if (live) begin
            byte_position_ff <= byte_position_ff + 1'b1;
            unique case (phase_ff)
               sbsd_pkg::PH_OPCODE: begin
                  instr_offset_ff <= byte_position_ff;
                  held_major_ff   <= byte_major;
                  held_minor_ff   <= byte_minor;
                  more_words_ff   <= byte_info.count == 2'd2;
               end
               sbsd_pkg::PH_OPERAND: begin
                  if (word_done) begin
                     more_words_ff <= 1'b0;
                     if (more_words_ff) begin
                        saved_first_ff <= word_value;
                     end else if (held_info.count == 2'd2 && capt_start) begin
                        captures_left_ff <= word_value;
                     end
                  end
               end
               sbsd_pkg::PH_AREA: begin
                  held_area_ff <= code_byte[1:0];
               end
               sbsd_pkg::PH_INDEX: begin
                  if (word_done) begin
                     captures_left_ff <= captures_left_ff - 1'b1;
                  end
               end
               default: held_area_ff <= held_area_ff;
            endcase
         end
      end
   end
endmodule

>>> sv/stack_bytecode_stream_decoder.sv
// Top level of the stack bytecode stream decoder: input register, decoder, result register.
// Depends on sbsd_pkg, sbsd_if and sbsd_decoder.
//
//   channel   dir   payload                                   transaction
//   req_ch    in    code_byte[7:0]                            one code byte
//   rsp_ch    out   kind, start_offset, major/minor_code,     one decoded instruction,
//                   first/second_operand, operand_count,      capture, end or error
//                   capture_area, last_of_instruction
//
// One byte per cycle sustained while responses are taken. A byte is held in the
// input register, is decoded there by the state machine and its result (if any)
// lands in the result register.
// Synchronous active-high reset returns to opcode phase at offset zero and
// clears the halt. A stalled response holds the input register; ready drops
// only when both registers are full and the response is not taken.
// After an end or error response, bytes are accepted and dropped until reset.
module stack_bytecode_stream_decoder #(
   parameter int OFFSET_BITS   = sbsd_pkg::OFFSET_BITS_DEF,
   parameter int OPERAND_BYTES = sbsd_pkg::OPERAND_BYTES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   sbsd_req_if.sink   req_ch,
   sbsd_rsp_if.source rsp_ch
);
   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   // result stage
   logic                      rsp_valid_ff, rsp_valid_in;
   sbsd_pkg::rsp_payload_type rsp_data_ff;

   logic                      advance;   // result slot free this cycle
   logic                      process;   // held byte goes through the decoder
   logic                      req_take;
   logic                      emit;
   sbsd_pkg::rsp_payload_type payload;

   assign advance  = !rsp_valid_ff || rsp_ch.ready;
   assign process  = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_take ? 1'b1 : (process ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (process && emit) ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   sbsd_decoder #(
      .OFFSET_BITS   (OFFSET_BITS),
      .OPERAND_BYTES (OPERAND_BYTES)
   ) u_decoder (
      .clock     (clock),
      .reset     (reset),
      .step      (process),
      .code_byte (in_byte_ff),
      .emit      (emit),
      .payload   (payload)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_ch.code_byte;
      end
      if (process && emit) begin
         rsp_data_ff <= payload;
      end
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.kind                = rsp_data_ff.kind;
   assign rsp_ch.start_offset        = rsp_data_ff.start_offset;
   assign rsp_ch.major_code          = rsp_data_ff.major_code;
   assign rsp_ch.minor_code          = rsp_data_ff.minor_code;
   assign rsp_ch.first_operand       = rsp_data_ff.first_operand;
   assign rsp_ch.second_operand      = rsp_data_ff.second_operand;
   assign rsp_ch.operand_count       = rsp_data_ff.operand_count;
   assign rsp_ch.capture_area        = rsp_data_ff.capture_area;
   assign rsp_ch.last_of_instruction = rsp_data_ff.last_of_instruction;
endmodule
